### sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// Shared types, constants and helper functions for the one-wire bus master.
// ----------------------------------------------------------------------------
package owm_pkg;

    // timer and byte geometry
    localparam int TIMER_WIDTH = 10;
    localparam int BYTE_BITS   = 8;
    localparam int BIT_IDX_W   = $clog2(BYTE_BITS);
    localparam int CFG_W       = 10;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int PADDR_W     = REG_IDX_W + 2;
    localparam int PDATA_W     = 32;

    // command codes
    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ONE_LOW       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ONE_RELEASE   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_READ_TAIL     = 3'd7;

    // register reset values, in register index order
    localparam logic [CFG_W-1:0] REG_RESET_VALS [NUM_REGS] = '{
        10'd480, 10'd80, 10'd400, 10'd1, 10'd60, 10'd60, 10'd2, 10'd60
    };

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_SAMPLE,
        PH_RST_TAIL,
        PH_W_LOW,
        PH_W_REL,
        PH_R_LOW,
        PH_R_SAMPLE,
        PH_R_TAIL
    } phase_t;

    // slot timing registers as seen by the core
    typedef struct packed {
        logic [CFG_W-1:0] reset_low_ticks;
        logic [CFG_W-1:0] presence_wait_ticks;
        logic [CFG_W-1:0] reset_tail_ticks;
        logic [CFG_W-1:0] one_low_ticks;
        logic [CFG_W-1:0] zero_low_ticks;
        logic [CFG_W-1:0] one_release_ticks;
        logic [CFG_W-1:0] read_low_ticks;
        logic [CFG_W-1:0] read_tail_ticks;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic                 drive_low;
        logic                 busy_res;
        logic                 done_res;
        logic                 presence;
        logic [BYTE_BITS-1:0] rx_byte;
    } res_t;

    typedef struct packed {
        logic                   last;
        logic [TIMER_WIDTH-1:0] count;
    } adv_t;

    // zero acts as one, values above the timer range saturate
    function automatic logic [TIMER_WIDTH-1:0] eff_limit(input logic [CFG_W-1:0] v);
        logic [TIMER_WIDTH+CFG_W-1:0] wide;
        logic [TIMER_WIDTH+CFG_W-1:0] tmax;
        wide = {{TIMER_WIDTH{1'b0}}, v};
        tmax = {{CFG_W{1'b0}}, {TIMER_WIDTH{1'b1}}};
        if (v == '0) begin
            wide = {{(TIMER_WIDTH+CFG_W-1){1'b0}}, 1'b1};
        end else if (wide > tmax) begin
            wide = tmax;
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

    // count one tick of a slot part, flag the last tick
    function automatic adv_t tick_adv(input logic [TIMER_WIDTH-1:0] tc,
                                      input logic [TIMER_WIDTH-1:0] lim);
        adv_t             r;
        logic [TIMER_WIDTH:0] sum;
        sum    = {1'b0, tc} + {{TIMER_WIDTH{1'b0}}, 1'b1};
        r.last = (sum >= {1'b0, lim});
        r.count = r.last ? '0 : sum[TIMER_WIDTH-1:0];
        return r;
    endfunction

endpackage

### sv/owm_regs.sv
// ----------------------------------------------------------------------------
// owm_regs
// APB register file holding the slot timing registers.
// ----------------------------------------------------------------------------
module owm_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owm_pkg::PADDR_W-1:0]   paddr,
    input  logic [owm_pkg::PDATA_W-1:0]   pwdata,
    output logic [owm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output owm_pkg::cfg_t                 cfg
);
    import owm_pkg::*;

    logic [CFG_W-1:0]     regs_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] idx;
    logic                 wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;

    // register write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                regs_reg[i] <= REG_RESET_VALS[i];
            end
        end else if (wr_en) begin
            regs_reg[idx] <= pwdata[CFG_W-1:0];
        end
    end

    // read back
    assign prdata = {{(PDATA_W-CFG_W){1'b0}}, regs_reg[idx]};

    // register view for the core
    assign cfg.reset_low_ticks     = regs_reg[REG_RESET_LOW];
    assign cfg.presence_wait_ticks = regs_reg[REG_PRESENCE_WAIT];
    assign cfg.reset_tail_ticks    = regs_reg[REG_RESET_TAIL];
    assign cfg.one_low_ticks       = regs_reg[REG_ONE_LOW];
    assign cfg.zero_low_ticks      = regs_reg[REG_ZERO_LOW];
    assign cfg.one_release_ticks   = regs_reg[REG_ONE_RELEASE];
    assign cfg.read_low_ticks      = regs_reg[REG_READ_LOW];
    assign cfg.read_tail_ticks     = regs_reg[REG_READ_TAIL];

endmodule

### sv/owm_core.sv
// ----------------------------------------------------------------------------
// owm_core
// Bus sequencer: advances the slot state by one tick per step and forms the
// result of that tick.
// ----------------------------------------------------------------------------
module owm_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic                            start_req,
    input  logic [1:0]                      cmd,
    input  logic [owm_pkg::BYTE_BITS-1:0]   tx_byte,
    input  logic                            line_level,
    input  owm_pkg::cfg_t                   cfg,
    output owm_pkg::res_t                   res
);
    import owm_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [BYTE_BITS-1:0]   shift_reg, shift_next;
    logic                   presence_reg, presence_next;
    logic [BYTE_BITS-1:0]   rx_reg, rx_next;

    logic [CFG_W-1:0]       raw_lim;
    adv_t                   adv;
    logic                   slot_end;
    logic                   drive;
    logic                   done;
    logic                   busy;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_reg      <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            rx_reg       <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            rx_reg       <= rx_next;
        end
    end

    // one tick of the sequencer
    always_comb begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_next      = bit_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        rx_next       = rx_reg;
        drive         = 1'b0;
        done          = 1'b0;
        slot_end      = 1'b0;

        // command start while idle
        if (phase_reg == PH_IDLE && start_req &&
            (cmd inside {CMD_RESET, CMD_WRITE, CMD_READ})) begin
            shift_next = (cmd == CMD_WRITE) ? tx_byte : '0;
            bit_next   = '0;
            tick_next  = '0;
            case (cmd)
                CMD_RESET: phase_next = PH_RST_LOW;
                CMD_WRITE: phase_next = PH_W_LOW;
                default:   phase_next = PH_R_LOW;
            endcase
        end
        busy = (phase_next != PH_IDLE);

        // limit of the current slot part
        case (phase_next)
            PH_RST_LOW:  raw_lim = cfg.reset_low_ticks;
            PH_RST_WAIT: raw_lim = cfg.presence_wait_ticks;
            PH_RST_TAIL: raw_lim = cfg.reset_tail_ticks;
            PH_W_LOW:    raw_lim = shift_next[bit_next] ? cfg.one_low_ticks
                                                        : cfg.zero_low_ticks;
            PH_W_REL:    raw_lim = shift_next[bit_next] ? cfg.one_release_ticks
                                                        : CFG_W'(1);
            PH_R_LOW:    raw_lim = cfg.read_low_ticks;
            PH_R_TAIL:   raw_lim = cfg.read_tail_ticks;
            default:     raw_lim = CFG_W'(1);
        endcase
        adv = tick_adv(tick_next, eff_limit(raw_lim));

        // phase actions
        case (phase_next)
            PH_RST_LOW: begin
                drive     = 1'b1;
                tick_next = adv.count;
                if (adv.last) phase_next = PH_RST_WAIT;
            end
            PH_RST_WAIT: begin
                tick_next = adv.count;
                if (adv.last) phase_next = PH_RST_SAMPLE;
            end
            PH_RST_SAMPLE: begin
                presence_next = ~line_level;
                tick_next     = '0;
                if (cfg.reset_tail_ticks == '0) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    phase_next = PH_RST_TAIL;
                end
            end
            PH_RST_TAIL: begin
                tick_next = adv.count;
                if (adv.last) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            PH_W_LOW: begin
                drive     = 1'b1;
                tick_next = adv.count;
                if (adv.last) phase_next = PH_W_REL;
            end
            PH_W_REL: begin
                tick_next = adv.count;
                slot_end  = adv.last;
            end
            PH_R_LOW: begin
                drive     = 1'b1;
                tick_next = adv.count;
                if (adv.last) phase_next = PH_R_SAMPLE;
            end
            PH_R_SAMPLE: begin
                if (line_level) shift_next[bit_next] = 1'b1;
                tick_next  = '0;
                phase_next = PH_R_TAIL;
            end
            PH_R_TAIL: begin
                tick_next = adv.count;
                slot_end  = adv.last;
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        // end of a bit slot
        if (slot_end) begin
            if (bit_next == BIT_IDX_W'(BYTE_BITS - 1)) begin
                if (phase_next == PH_R_TAIL) rx_next = shift_next;
                done       = 1'b1;
                phase_next = PH_IDLE;
                bit_next   = '0;
            end else begin
                bit_next   = bit_next + BIT_IDX_W'(1);
                phase_next = (phase_next == PH_W_REL) ? PH_W_LOW : PH_R_LOW;
            end
            tick_next = '0;
        end

        res.drive_low = drive;
        res.busy_res  = busy;
        res.done_res  = done;
        res.presence  = presence_next;
        res.rx_byte   = rx_next;
    end

endmodule

### sv/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master stepped by one tick item per transfer, with APB slot
// timing registers.
//
//   channel   ports            direction   contents
//   s_        valid/ready      in          tick: start_req, cmd, tx_byte, line_level
//   m_        valid/ready      out         drive_low, busy_res, done_res, presence, rx_byte
//   apb       psel..prdata     in/out      eight 10-bit timing registers at 4*i
//
// One result per tick; a tick is accepted every cycle while the output side
// keeps up. Each tick goes through the input register, then the sequencer step
// into the result register. aresetn is synchronous and clears the sequencer,
// the valid flags and the timing registers. A stall on m_ready holds the result
// register and the input register, and s_ready drops once both are full.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tick input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_start_req,
    input  logic [1:0]                      s_cmd,
    input  logic [owm_pkg::BYTE_BITS-1:0]   s_tx_byte,
    input  logic                            s_line_level,
    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_drive_low,
    output logic                            m_busy_res,
    output logic                            m_done_res,
    output logic                            m_presence,
    output logic [owm_pkg::BYTE_BITS-1:0]   m_rx_byte,
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owm_pkg::PADDR_W-1:0]     paddr,
    input  logic [owm_pkg::PDATA_W-1:0]     pwdata,
    output logic [owm_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import owm_pkg::*;

    logic                 in_valid_reg;
    logic                 start_reg;
    logic [1:0]           cmd_reg;
    logic [BYTE_BITS-1:0] tx_reg;
    logic                 line_reg;
    logic                 out_valid_reg;
    res_t                 out_reg;

    cfg_t                 cfg;
    res_t                 res;
    logic                 step;
    logic                 s_fire;

    // a step moves the held tick into the result register
    assign step    = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | step;
    assign s_fire  = s_valid & s_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            start_reg <= s_start_req;
            cmd_reg   <= s_cmd;
            tx_reg    <= s_tx_byte;
            line_reg  <= s_line_level;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_reg <= res;
        end
    end

    owm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    owm_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .start_req  (start_reg),
        .cmd        (cmd_reg),
        .tx_byte    (tx_reg),
        .line_level (line_reg),
        .cfg        (cfg),
        .res        (res)
    );

    // result ports
    assign m_valid     = out_valid_reg;
    assign m_drive_low = out_reg.drive_low;
    assign m_busy_res  = out_reg.busy_res;
    assign m_done_res  = out_reg.done_res;
    assign m_presence  = out_reg.presence;
    assign m_rx_byte   = out_reg.rx_byte;

endmodule
